[hdl/hhc_pkg.sv]
// ----------------------------------------------------------------------------
// hhc_pkg
// Types and constants shared by the height-to-heatmap colour mapper.
// ----------------------------------------------------------------------------
package hhc_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int SAMPLE_W        = 16;
  localparam int CHAN_W          = 8;
  localparam int DIV_W           = SAMPLE_W;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = (FRAC_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CHAN_W-1:0]          chan_t;
  typedef logic [FRAC_BITS:0]         frac_t;
  typedef logic [2:0]                 sector_t;

  typedef enum logic {
    REG_RANGE_MIN,
    REG_RANGE_MAX
  } reg_idx_t;

  typedef enum logic [2:0] {
    SECT_RED_YELLOW,
    SECT_YELLOW_GREEN,
    SECT_GREEN_CYAN,
    SECT_CYAN_BLUE,
    SECT_BLUE
  } sector_e;

  localparam frac_t   ONE_FIX         = {1'b1, {FRAC_BITS{1'b0}}};
  localparam chan_t   CHAN_FULL       = {CHAN_W{1'b1}};
  localparam chan_t   CHAN_EMPTY      = '0;
  localparam chan_t   ALPHA_OPAQUE    = {CHAN_W{1'b1}};
  localparam sample_t RANGE_MIN_RESET = -16'sd1000;
  localparam sample_t RANGE_MAX_RESET = 16'sd1000;

  typedef struct packed {
    logic                 is_div;
    logic                 p_one;
    logic [DIV_W-1:0]     rem;
    logic [DIV_W-1:0]     dvsr;
    logic [FRAC_BITS-1:0] quo;
  } div_stage_t;

endpackage

[hdl/hhc_sample_if.sv]
// ----------------------------------------------------------------------------
// hhc_sample_if
// Valid/ready channel carrying one signed height sample.
// ----------------------------------------------------------------------------
interface hhc_sample_if import hhc_pkg::*; ();

  logic    valid;
  logic    ready;
  sample_t height;

  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);

endinterface

[hdl/hhc_pixel_if.sv]
// ----------------------------------------------------------------------------
// hhc_pixel_if
// Valid/ready channel carrying one RGBA pixel.
// ----------------------------------------------------------------------------
interface hhc_pixel_if import hhc_pkg::*; ();

  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  chan_t alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);

endinterface

[hdl/height_to_heatmap_color.sv]
// ----------------------------------------------------------------------------
// height_to_heatmap_color
// Maps a signed height sample to a blue-to-red false-colour RGBA pixel.
//
// sample carries one height per transaction; pixel returns one RGBA colour
// per sample, in order. Alpha is always opaque. range_min (address 0) and
// range_max (address 4) are written through the APB port; write them only
// while no sample is in flight.
// The stages form the offset and span, run the restoring divider two quotient
// bits at a time, pick the hue sector and then scale the channels.
// Throughput is one sample per cycle while pixel.ready is high; each stage
// advances on its own, so bubbles close up and a stalled pixel holds while
// upstream stages fill. Reset empties the pipeline and loads
// range_min = -1000 and range_max = 1000. While pixel.ready is low the last
// pixel is held and sample.ready falls only once every stage is occupied.
// ----------------------------------------------------------------------------
module height_to_heatmap_color import hhc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  hhc_sample_if.sink            sample,
  hhc_pixel_if.source           pixel
);

  sample_t range_min;
  sample_t range_max;
  reg_idx_t reg_sel;
  logic     reg_wr;

  logic signed [SAMPLE_W:0] diff;
  logic signed [SAMPLE_W:0] span;
  div_stage_t               pre_next;

  logic       pre_v;
  div_stage_t pre;

  logic [DIV_STAGES-1:0] div_v;
  logic [DIV_STAGES-1:0] div_en;
  div_stage_t            div_q    [DIV_STAGES];
  div_stage_t            div_next [DIV_STAGES];

  logic    en_pre;
  logic    en_hue;
  logic    en_out;

  frac_t               p_val;
  frac_t               q_val;
  logic [FRAC_BITS+2:0] q4;
  sector_t             sector_next;
  frac_t               x_next;

  logic    hue_v;
  sector_t hue_sector;
  frac_t   hue_x;

  logic [FRAC_BITS+8:0] scaled;
  chan_t                xs;
  chan_t                red_next;
  chan_t                green_next;
  chan_t                blue_next;

  logic  out_v;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_RANGE_MIN: prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, range_min};
      REG_RANGE_MAX: prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, range_max};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    en_out = !out_v || pixel.ready;
    en_hue = !hue_v || en_out;
    div_en[DIV_STAGES-1] = !div_v[DIV_STAGES-1] || en_hue;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      div_en[k] = !div_v[k] || div_en[k+1];
    end
    en_pre = !pre_v || div_en[0];
  end

  assign sample.ready = en_pre;

  always_comb begin
    diff = {sample.height[SAMPLE_W-1], sample.height} - {range_min[SAMPLE_W-1], range_min};
    span = {range_max[SAMPLE_W-1], range_max} - {range_min[SAMPLE_W-1], range_min};
    pre_next.is_div = (span > 0) && (diff > 0) && (diff < span);
    pre_next.p_one  = (span <= 0) ? (diff > 0) : (diff >= span);
    pre_next.rem    = diff[DIV_W-1:0];
    pre_next.dvsr   = span[DIV_W-1:0];
    pre_next.quo    = '0;
  end

  always_comb begin : div_comb
    div_stage_t       cur;
    logic [DIV_W:0]   trial;
    for (int k = 0; k < DIV_STAGES; k++) begin
      cur = (k == 0) ? pre : div_q[(k == 0) ? 0 : k - 1];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (k * STEPS_PER_STAGE + j < FRAC_BITS) begin
          trial = {cur.rem, 1'b0};
          if (trial >= {1'b0, cur.dvsr}) begin
            trial   = trial - {1'b0, cur.dvsr};
            cur.quo = {cur.quo[FRAC_BITS-2:0], 1'b1};
          end else begin
            cur.quo = {cur.quo[FRAC_BITS-2:0], 1'b0};
          end
          cur.rem = trial[DIV_W-1:0];
        end
      end
      div_next[k] = cur;
    end
  end

  always_comb begin
    if (div_q[DIV_STAGES-1].is_div) begin
      p_val = {1'b0, div_q[DIV_STAGES-1].quo};
    end else if (div_q[DIV_STAGES-1].p_one) begin
      p_val = ONE_FIX;
    end else begin
      p_val = '0;
    end
    q_val       = ONE_FIX - p_val;
    q4          = {q_val, 2'b00};
    sector_next = q4[FRAC_BITS+2:FRAC_BITS];
    if (sector_next[0]) begin
      x_next = ONE_FIX - {1'b0, q4[FRAC_BITS-1:0]};
    end else begin
      x_next = {1'b0, q4[FRAC_BITS-1:0]};
    end
  end

  always_comb begin
    scaled = {hue_x, 8'b0} - {8'b0, hue_x};
    xs     = scaled[FRAC_BITS+7:FRAC_BITS];
    case (sector_e'(hue_sector))
      SECT_RED_YELLOW: begin
        red_next = CHAN_FULL; green_next = xs; blue_next = CHAN_EMPTY;
      end
      SECT_YELLOW_GREEN: begin
        red_next = xs; green_next = CHAN_FULL; blue_next = CHAN_EMPTY;
      end
      SECT_GREEN_CYAN: begin
        red_next = CHAN_EMPTY; green_next = CHAN_FULL; blue_next = xs;
      end
      SECT_CYAN_BLUE: begin
        red_next = CHAN_EMPTY; green_next = xs; blue_next = CHAN_FULL;
      end
      default: begin
        red_next = xs; green_next = CHAN_EMPTY; blue_next = CHAN_FULL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= RANGE_MIN_RESET;
      range_max <= RANGE_MAX_RESET;
      pre_v     <= 1'b0;
      div_v     <= '0;
      hue_v     <= 1'b0;
      out_v     <= 1'b0;
    end else begin
      if (reg_wr) begin
        case (reg_sel)
          REG_RANGE_MIN: range_min <= sample_t'(pwdata[SAMPLE_W-1:0]);
          REG_RANGE_MAX: range_max <= sample_t'(pwdata[SAMPLE_W-1:0]);
          default: ;
        endcase
      end
      if (en_pre) begin
        pre_v <= sample.valid;
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (div_en[k]) begin
          div_v[k] <= (k == 0) ? pre_v : div_v[(k == 0) ? 0 : k - 1];
        end
      end
      if (en_hue) begin
        hue_v <= div_v[DIV_STAGES-1];
      end
      if (en_out) begin
        out_v <= hue_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_pre) begin
      pre <= pre_next;
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (div_en[k]) begin
        div_q[k] <= div_next[k];
      end
    end
    if (en_hue) begin
      hue_sector <= sector_next;
      hue_x      <= x_next;
    end
    if (en_out) begin
      out_red   <= red_next;
      out_green <= green_next;
      out_blue  <= blue_next;
    end
  end

  assign pixel.valid = out_v;
  assign pixel.red   = out_red;
  assign pixel.green = out_green;
  assign pixel.blue  = out_blue;
  assign pixel.alpha = ALPHA_OPAQUE;

  a_reset_empty: assert property (@(posedge clk) rst |=> !pixel.valid && !hue_v && !pre_v)
    else $error("pipeline not empty after reset");

  a_hue_has_full: assert property (@(posedge clk) disable iff (rst)
    pixel.valid |-> (pixel.red == CHAN_FULL || pixel.green == CHAN_FULL ||
                     pixel.blue == CHAN_FULL))
    else $error("no channel at full scale");

  a_hue_has_empty: assert property (@(posedge clk) disable iff (rst)
    pixel.valid |-> (pixel.red == CHAN_EMPTY || pixel.green == CHAN_EMPTY ||
                     pixel.blue == CHAN_EMPTY))
    else $error("no channel at zero");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    hue_v && hue_sector == SECT_BLUE |-> hue_x == '0)
    else $error("blue sector with non-zero ramp");

endmodule
